// ===== rtl/cgts_pkg.sv =====
// Shared types and constants for the change-gated telemetry sampler.
`timescale 1ns / 1ps

package cgts_pkg;

    localparam int AXES       = 5;
    localparam int POS_W      = 32;
    localparam int SPD_W      = 20;
    localparam int TIME_W     = 64;
    localparam int SEQ_W      = 32;
    localparam int TICK_W     = 32;
    localparam int AXC_W      = 3;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 32;
    localparam int IN_USER_W  = 2;

    localparam int IN_FIELDS_W  = AXES * POS_W + TIME_W + 2 * SPD_W + 1;
    localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = SEQ_W + TIME_W + AXES * POS_W + 2 * SPD_W;
    localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

    localparam int IN_TIME_LSB  = AXES * POS_W;
    localparam int IN_ACT_LSB   = IN_TIME_LSB + TIME_W;
    localparam int IN_TGT_LSB   = IN_ACT_LSB + SPD_W;
    localparam int IN_SPIN_BIT  = IN_TGT_LSB + SPD_W;

    localparam int OUT_TIME_LSB = SEQ_W;
    localparam int OUT_POS_LSB  = SEQ_W + TIME_W;
    localparam int OUT_ACT_LSB  = OUT_POS_LSB + AXES * POS_W;
    localparam int OUT_TGT_LSB  = OUT_ACT_LSB + SPD_W;

    localparam logic [SPD_W-1:0] SPEED_DELTA = SPD_W'(160);
    localparam logic [SPD_W-1:0] SPIN_LEVEL  = SPD_W'(8);

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_SINK_ENABLED  = 2'd0,
        CFG_AXIS_COUNT    = 2'd1,
        CFG_TICK_INTERVAL = 2'd2,
        CFG_TIME_INTERVAL = 2'd3
    } cfg_addr_t;

    typedef enum logic {
        REQ_OBSERVE = 1'b0,
        REQ_CLEAR   = 1'b1
    } req_type_t;

    typedef struct packed {
        logic              sink_enabled;
        logic [AXC_W-1:0]  axis_used;
        logic [TICK_W-1:0] tick_interval;
        logic [TICK_W-1:0] time_interval;
    } cfg_t;

    typedef struct packed {
        logic clear;
        logic load_seen;
        logic load_sent;
    } lane_ctl_t;

    typedef struct packed {
        logic diff_seen;
        logic diff_sent;
    } lane_flags_t;

endpackage

// ===== rtl/change_gated_telemetry_sampler_unit.sv =====
// Top level: config registers, axis lanes, merge stage and output register.
// A sample appears on the output in the cycle after its observation is accepted.
// Throughput: one observation per cycle while the output register is free; all gating resolves in the accept cycle.
// Input is held off only while a sample waits in the output register unaccepted.
// Reset (rst_n low, async): sink disabled, axis count 5, intervals 1, history cleared,
// sequence restarts at one; writing sink_enabled also clears history.
`timescale 1ns / 1ps

module change_gated_telemetry_sampler_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [cgts_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [cgts_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // pos_a, pos_b, pos_c, pos_d, pos_e, now_us, spin_actual, spin_target, spinning, pad
    input  logic [cgts_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    // req_type, force_req
    input  logic [cgts_pkg::IN_USER_W-1:0]      s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // seq_no, stamp_us, out_a, out_b, out_c, out_d, out_e, out_actual, out_target
    output logic [cgts_pkg::OUT_DATA_W-1:0]     m_axis_tdata
);

    cgts_pkg::cfg_t                     cfg_reg;
    logic                               cfg_clear;
    logic                               accept;
    logic signed [cgts_pkg::POS_W-1:0]  pos      [cgts_pkg::AXES];
    logic signed [cgts_pkg::POS_W-1:0]  pos_used [cgts_pkg::AXES];
    cgts_pkg::lane_flags_t              flags    [cgts_pkg::AXES];
    cgts_pkg::lane_ctl_t                lane_ctl;
    logic                               emit;
    logic [cgts_pkg::SEQ_W-1:0]         seq_no;
    logic [cgts_pkg::OUT_DATA_W-1:0]    out_data_next;
    logic [cgts_pkg::OUT_DATA_W-1:0]    out_data_reg;
    logic                               out_valid_reg;
    logic [cgts_pkg::AXC_W-1:0]         axc_in;

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    assign cfg_clear = cfg_we && cfg_addr == cgts_pkg::CFG_SINK_ENABLED;
    assign axc_in    = cfg_data[cgts_pkg::AXC_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sink_enabled  <= 1'b0;
            cfg_reg.axis_used     <= cgts_pkg::AXC_W'(cgts_pkg::AXES);
            cfg_reg.tick_interval <= cgts_pkg::TICK_W'(1);
            cfg_reg.time_interval <= cgts_pkg::TICK_W'(1);
        end
        else if (cfg_we)
        begin
            unique case (cgts_pkg::cfg_addr_t'(cfg_addr))
                cgts_pkg::CFG_SINK_ENABLED:
                begin
                    cfg_reg.sink_enabled <= cfg_data[0];
                end
                cgts_pkg::CFG_AXIS_COUNT:
                begin
                    cfg_reg.axis_used <= (axc_in > cgts_pkg::AXC_W'(cgts_pkg::AXES))
                                         ? cgts_pkg::AXC_W'(cgts_pkg::AXES) : axc_in;
                end
                cgts_pkg::CFG_TICK_INTERVAL:
                begin
                    cfg_reg.tick_interval <= (cfg_data == '0) ? cgts_pkg::TICK_W'(1)
                                                              : cfg_data;
                end
                cgts_pkg::CFG_TIME_INTERVAL:
                begin
                    cfg_reg.time_interval <= (cfg_data == '0) ? cgts_pkg::TICK_W'(1)
                                                              : cfg_data;
                end
                default:
                begin
                    cfg_reg <= cfg_reg;
                end
            endcase
        end
    end

    for (genvar g = 0; g < cgts_pkg::AXES; g++)
    begin : g_lane
        assign pos[g] = s_axis_tdata[g*cgts_pkg::POS_W +: cgts_pkg::POS_W];

        cgts_lane u_lane (
            .clk      (clk),
            .rst_n    (rst_n),
            .active   (cgts_pkg::AXC_W'(g) < cfg_reg.axis_used),
            .pos      (pos[g]),
            .ctl      (lane_ctl),
            .pos_used (pos_used[g]),
            .flags    (flags[g])
        );
    end

    cgts_merge u_merge (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .cfg_clear   (cfg_clear),
        .accept      (accept),
        .req_type    (s_axis_tuser[0]),
        .force_req   (s_axis_tuser[1]),
        .now_us      (s_axis_tdata[cgts_pkg::IN_TIME_LSB +: cgts_pkg::TIME_W]),
        .spin_actual (s_axis_tdata[cgts_pkg::IN_ACT_LSB +: cgts_pkg::SPD_W]),
        .spin_target (s_axis_tdata[cgts_pkg::IN_TGT_LSB +: cgts_pkg::SPD_W]),
        .spinning    (s_axis_tdata[cgts_pkg::IN_SPIN_BIT]),
        .flags       (flags),
        .lane_ctl    (lane_ctl),
        .emit        (emit),
        .seq_no      (seq_no)
    );

    always_comb
    begin
        out_data_next = '0;
        out_data_next[0 +: cgts_pkg::SEQ_W] = seq_no;
        out_data_next[cgts_pkg::OUT_TIME_LSB +: cgts_pkg::TIME_W] =
            s_axis_tdata[cgts_pkg::IN_TIME_LSB +: cgts_pkg::TIME_W];
        for (int i = 0; i < cgts_pkg::AXES; i++)
        begin
            out_data_next[cgts_pkg::OUT_POS_LSB + i*cgts_pkg::POS_W +: cgts_pkg::POS_W] =
                pos_used[i];
        end
        out_data_next[cgts_pkg::OUT_ACT_LSB +: cgts_pkg::SPD_W] =
            s_axis_tdata[cgts_pkg::IN_ACT_LSB +: cgts_pkg::SPD_W];
        out_data_next[cgts_pkg::OUT_TGT_LSB +: cgts_pkg::SPD_W] =
            s_axis_tdata[cgts_pkg::IN_TGT_LSB +: cgts_pkg::SPD_W];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept && emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && emit)
        begin
            out_data_reg <= out_data_next;
        end
    end

endmodule

// ===== rtl/cgts_lane.sv =====
// One axis lane: position history and change compares.
`timescale 1ns / 1ps

module cgts_lane (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                active,
    input  logic signed [cgts_pkg::POS_W-1:0]   pos,
    input  cgts_pkg::lane_ctl_t                 ctl,
    output logic signed [cgts_pkg::POS_W-1:0]   pos_used,
    output cgts_pkg::lane_flags_t               flags
);

    logic signed [cgts_pkg::POS_W-1:0] seen_pos_reg;
    logic signed [cgts_pkg::POS_W-1:0] sent_pos_reg;

    assign pos_used        = active ? pos : '0;
    assign flags.diff_seen = active && (pos != seen_pos_reg);
    assign flags.diff_sent = active && (pos != sent_pos_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_pos_reg <= '0;
            sent_pos_reg <= '0;
        end
        else if (ctl.clear)
        begin
            seen_pos_reg <= '0;
            sent_pos_reg <= '0;
        end
        else
        begin
            if (ctl.load_seen)
            begin
                seen_pos_reg <= pos_used;
            end
            if (ctl.load_sent)
            begin
                sent_pos_reg <= pos_used;
            end
        end
    end

endmodule

// ===== rtl/cgts_merge.sv =====
// Merge stage: combines lane flags with spindle, tick and time gating.
`timescale 1ns / 1ps

module cgts_merge (
    input  logic                              clk,
    input  logic                              rst_n,
    input  cgts_pkg::cfg_t                    cfg,
    input  logic                              cfg_clear,
    input  logic                              accept,
    input  logic                              req_type,
    input  logic                              force_req,
    input  logic [cgts_pkg::TIME_W-1:0]       now_us,
    input  logic [cgts_pkg::SPD_W-1:0]        spin_actual,
    input  logic [cgts_pkg::SPD_W-1:0]        spin_target,
    input  logic                              spinning,
    input  cgts_pkg::lane_flags_t             flags [cgts_pkg::AXES],
    output cgts_pkg::lane_ctl_t               lane_ctl,
    output logic                              emit,
    output logic [cgts_pkg::SEQ_W-1:0]        seq_no
);

    logic [cgts_pkg::TICK_W-1:0] ticks_reg;
    logic [cgts_pkg::TICK_W-1:0] ticks_next;
    logic [cgts_pkg::SEQ_W-1:0]  seq_reg;
    logic                        seen_valid_reg;
    logic                        sent_valid_reg;
    logic [cgts_pkg::SPD_W-1:0]  sent_act_reg;
    logic [cgts_pkg::SPD_W-1:0]  sent_tgt_reg;
    logic [cgts_pkg::TIME_W-1:0] sent_time_reg;

    logic [cgts_pkg::AXES-1:0]   seen_diff;
    logic [cgts_pkg::AXES-1:0]   sent_diff;
    logic                        has_axes;
    logic                        observe;
    logic                        prime;
    logic                        changed;
    logic                        spin_changed;
    logic [cgts_pkg::SPD_W-1:0]  da;
    logic [cgts_pkg::SPD_W-1:0]  dt;
    logic [cgts_pkg::TIME_W:0]   dtime;
    logic                        tick_el;
    logic                        time_el;
    logic                        elapsed;
    logic                        dup;
    logic                        hist_clear;

    always_comb
    begin
        for (int i = 0; i < cgts_pkg::AXES; i++)
        begin
            seen_diff[i] = flags[i].diff_seen;
            sent_diff[i] = flags[i].diff_sent;
        end

        has_axes   = (cfg.axis_used != '0);
        hist_clear = cfg_clear || (accept && req_type == cgts_pkg::REQ_CLEAR);
        observe    = accept && req_type == cgts_pkg::REQ_OBSERVE && cfg.sink_enabled;
        prime      = !force_req && !seen_valid_reg && has_axes;

        ticks_next = (!force_req && ticks_reg != '1) ? ticks_reg + 1'b1 : ticks_reg;

        changed = seen_valid_reg ? (|seen_diff) : has_axes;

        da = (spin_actual >= sent_act_reg) ? spin_actual - sent_act_reg
                                           : sent_act_reg - spin_actual;
        dt = (spin_target >= sent_tgt_reg) ? spin_target - sent_tgt_reg
                                           : sent_tgt_reg - spin_target;
        spin_changed = !sent_valid_reg || da >= cgts_pkg::SPEED_DELTA
                       || dt >= cgts_pkg::SPEED_DELTA
                       || (spinning != (sent_act_reg > cgts_pkg::SPIN_LEVEL));

        // top bit is the borrow: time ran backwards
        dtime   = {1'b0, now_us} - {1'b0, sent_time_reg};
        tick_el = ticks_next >= cfg.tick_interval;
        time_el = !sent_valid_reg || dtime[cgts_pkg::TIME_W]
                  || (dtime[cgts_pkg::TIME_W-1:0]
                      >= {{(cgts_pkg::TIME_W-cgts_pkg::TICK_W){1'b0}}, cfg.time_interval});
        elapsed = changed ? (tick_el || time_el) : time_el;

        dup = !force_req && sent_valid_reg && !(|sent_diff)
              && da < cgts_pkg::SPEED_DELTA && dt < cgts_pkg::SPEED_DELTA;

        emit = observe && !prime && !hist_clear
               && (force_req || changed || spin_changed)
               && (force_req || elapsed || !sent_valid_reg)
               && !dup;

        lane_ctl.clear     = hist_clear;
        lane_ctl.load_seen = observe;
        lane_ctl.load_sent = emit;
    end

    assign seq_no = seq_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ticks_reg      <= '0;
            seq_reg        <= cgts_pkg::SEQ_W'(1);
            seen_valid_reg <= 1'b0;
            sent_valid_reg <= 1'b0;
            sent_act_reg   <= '0;
            sent_tgt_reg   <= '0;
            sent_time_reg  <= '0;
        end
        else if (hist_clear)
        begin
            ticks_reg      <= '0;
            seq_reg        <= cgts_pkg::SEQ_W'(1);
            seen_valid_reg <= 1'b0;
            sent_valid_reg <= 1'b0;
            sent_act_reg   <= '0;
            sent_tgt_reg   <= '0;
            sent_time_reg  <= '0;
        end
        else if (observe)
        begin
            if (prime)
            begin
                seen_valid_reg <= 1'b1;
            end
            else
            begin
                seen_valid_reg <= has_axes;
                ticks_reg      <= emit ? '0 : ticks_next;
                if (emit)
                begin
                    seq_reg        <= seq_reg + 1'b1;
                    sent_valid_reg <= 1'b1;
                    sent_act_reg   <= spin_actual;
                    sent_tgt_reg   <= spin_target;
                    sent_time_reg  <= now_us;
                end
            end
        end
    end

endmodule
